@@ hw/rtl/spbf_pkg.sv @@
// ----------------------------------------------------------------------------
// spbf_pkg
// shared types and constants of the sprite blitter: operation codes, sheet
// geometry and the sheet write request
// ----------------------------------------------------------------------------
`default_nettype none

package spbf_pkg;

	// operation codes of an input transaction
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_DRAW = 1'b1
	} op_t;

	localparam int SHEET_AW    = 14;
	localparam int SHEET_DEPTH = 1 << SHEET_AW;
	localparam int SPRITE_W    = 8;
	localparam int BYTE_W      = 8;
	localparam int PIX_AW      = 14;
	localparam int COLOUR_W    = 4;
	localparam int PALETTE_W   = 64;

	localparam logic [PALETTE_W-1:0] PALETTE_RESET = 64'hFEDC_BA98_7654_3210;

	// one write request into the sheet memory
	typedef struct packed {
		logic                en;
		logic [SHEET_AW-1:0] addr;
		logic [BYTE_W-1:0]   data;
	} sheet_wr_t;

	// one read request into the sheet memory
	typedef struct packed {
		logic                en;
		logic [SHEET_AW-1:0] addr;
	} sheet_rd_t;

endpackage

`default_nettype wire

@@ hw/rtl/spbf_sheet_ram.sv @@
// ----------------------------------------------------------------------------
// spbf_sheet_ram
// sprite sheet storage, one write port and one read port, read data
// registered; the read data holds while no read is issued
// ----------------------------------------------------------------------------
`default_nettype none

module spbf_sheet_ram (
	input  wire logic                       clk,
	input  wire spbf_pkg::sheet_wr_t        wr,
	input  wire spbf_pkg::sheet_rd_t        rd,
	output logic [spbf_pkg::BYTE_W-1:0]     rd_data
);
	import spbf_pkg::*;

	logic [BYTE_W-1:0] mem [SHEET_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/sprite_blitter_flip_palette.sv @@
// ----------------------------------------------------------------------------
// sprite_blitter_flip_palette
// draws one 8x8 sprite from an on-chip sprite sheet as a run of 64
// framebuffer pixel writes, with mirroring and a 16-entry palette remap
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall): a load transaction writes one sheet
//   byte and gives no result. a draw transaction starts a run of 64 pixel
//   transactions in row-major screen order, the last one marked by last.
//   output channel (out_valid / out_stall): one pixel per transaction;
//   write_enable is low for transparent (zero) sheet bytes and off-screen
//   positions, and then address and colour read as zero.
//   a draw's first pixel passes draw context, stage 1 and output register.
//   throughput: a draw holds the input stalled until its 64th sheet read is
//   issued, one sheet read a cycle through the single read port unless the
//   output stalls; the next item is taken in the cycle after the 64th read.
//   receiver stall: the whole read pipeline (address issue, sheet read and
//   output register) freezes together, so the sheet read data and the
//   pixel on the port hold until the stall drops.
//   user must write palette_q by cfg_write/cfg_data only while idle; unchecked
//   reset: clears control state and sets the palette to identity; the sheet
//   content is undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_blitter_flip_palette #(
	parameter int SCREEN_SIZE   = 128,
	parameter int SHEET_SPRITES = 256
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_write,
	input  wire logic [spbf_pkg::PALETTE_W-1:0]    cfg_data,
	// input channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              operation,
	input  wire logic [spbf_pkg::SPRITE_W-1:0]     sprite_number,
	input  wire logic signed [8:0]                 screen_x,
	input  wire logic signed [8:0]                 screen_y,
	input  wire logic                              flip_horizontal,
	input  wire logic                              flip_vertical,
	input  wire logic [spbf_pkg::SHEET_AW-1:0]     load_address,
	input  wire logic [spbf_pkg::BYTE_W-1:0]       load_byte,
	// output channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [spbf_pkg::PIX_AW-1:0]            pixel_address,
	output logic [spbf_pkg::COLOUR_W-1:0]          pixel_colour,
	output logic                                   write_enable,
	output logic                                   last
);
	import spbf_pkg::*;

	// coordinate width: must hold -256..262 and SCREEN_SIZE itself, signed
	localparam int SCR_BITS = $clog2(SCREEN_SIZE + 1);
	localparam int CW       = (SCR_BITS > 9) ? SCR_BITS + 1 : 10;
	localparam int PW       = 2 * CW;
	localparam int NSPR     = 1 << SPRITE_W;

	// sprite number folded into the sheet, a constant table
	logic [SPRITE_W-1:0] spr_fold [NSPR];
	for (genvar i = 0; i < NSPR; i++) begin : g_fold
		assign spr_fold[i] = SPRITE_W'(i % SHEET_SPRITES);
	end

	// palette register
	logic [PALETTE_W-1:0] palette_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_q <= PALETTE_RESET;
		end else if (cfg_write) begin
			palette_q <= cfg_data;
		end
	end

	// pipeline advance: everything moves together when the output can move
	logic adv;
	logic out_valid_q;
	assign adv = !out_valid_q || !out_stall;

	// input transactions
	logic in_acc, draw_acc, load_acc;
	logic busy_q;
	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;
	assign draw_acc = in_acc && (operation == OP_DRAW);
	assign load_acc = in_acc && (operation == OP_LOAD);

	// draw context, held while the 64 pixels are issued
	logic [5:0]          k_q;
	logic [SPRITE_W-1:0] spr_q;
	logic signed [8:0]   sx_q, sy_q;
	logic                fh_q, fv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (draw_acc) begin
			busy_q <= 1'b1;
			k_q    <= '0;
		end else if (busy_q && adv) begin
			k_q <= k_q + 6'd1;
			if (k_q == 6'd63) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (draw_acc) begin
			spr_q <= spr_fold[sprite_number];
			sx_q  <= screen_x;
			sy_q  <= screen_y;
			fh_q  <= flip_horizontal;
			fv_q  <= flip_vertical;
		end
	end

	// issue stage: sheet address, screen position, on-screen test
	logic [2:0]            dx, dy, scol, srow;
	logic signed [CW-1:0]  x, y;
	logic                  on_screen;
	logic [PW-1:0]         lin;

	assign dx   = k_q[2:0];
	assign dy   = k_q[5:3];
	assign scol = fh_q ? ~dx : dx;
	assign srow = fv_q ? ~dy : dy;
	assign x    = CW'(sx_q) + CW'(signed'({1'b0, dx}));
	assign y    = CW'(sy_q) + CW'(signed'({1'b0, dy}));

	assign on_screen = !x[CW-1] && !y[CW-1]
		&& (x < CW'(SCREEN_SIZE)) && (y < CW'(SCREEN_SIZE));
	// row times screen width plus column
	assign lin = PW'(unsigned'(y)) * PW'(SCREEN_SIZE) + PW'(unsigned'(x));

	sheet_wr_t sheet_wr;
	sheet_rd_t sheet_rd;
	logic [BYTE_W-1:0] sheet_q;

	assign sheet_wr.en   = load_acc;
	assign sheet_wr.addr = load_address;
	assign sheet_wr.data = load_byte;
	assign sheet_rd.en   = adv;
	// sprite times 64 plus row and column inside the sprite
	assign sheet_rd.addr = {spr_q, srow, scol};

	spbf_sheet_ram u_sheet (
		.clk     (clk),
		.wr      (sheet_wr),
		.rd      (sheet_rd),
		.rd_data (sheet_q)
	);

	// stage 1: sheet read in flight, sideband carried alongside
	logic              v_s1;
	logic              on_s1;
	logic              last_s1;
	logic [PIX_AW-1:0] addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			on_s1   <= on_screen;
			last_s1 <= (k_q == 6'd63);
			addr_s1 <= lin[PIX_AW-1:0];
		end
	end

	// output register: transparency, palette remap, zeroing of disabled pixels
	logic                we_c;
	logic [COLOUR_W-1:0] colour_c;
	logic [PIX_AW-1:0]   addr_q;
	logic [COLOUR_W-1:0] colour_q;
	logic                we_q, last_q;

	assign we_c     = on_s1 && (sheet_q != '0);
	assign colour_c = palette_q[{sheet_q[3:0], 2'b00} +: COLOUR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_q   <= we_c ? addr_s1 : '0;
			colour_q <= we_c ? colour_c : '0;
			we_q     <= we_c;
			last_q   <= last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_address = addr_q;
	assign pixel_colour  = colour_q;
	assign write_enable  = we_q;
	assign last          = last_q;

endmodule

`default_nettype wire

@@ hw/rtl/spbf_checker.sv @@
// ----------------------------------------------------------------------------
// spbf_checker
// port-level checks of the sprite blitter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module spbf_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_stall,
	input wire logic                           operation,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic [spbf_pkg::PIX_AW-1:0]    pixel_address,
	input wire logic [spbf_pkg::COLOUR_W-1:0]  pixel_colour,
	input wire logic                           write_enable,
	input wire logic                           last
);
	import spbf_pkg::*;

	// a stalled pixel holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_address)
			&& $stable(pixel_colour) && $stable(write_enable) && $stable(last))
		else $error("stalled pixel changed");

	// a taken draw blocks the input side
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (operation == OP_DRAW) |=> in_stall)
		else $error("input not stalled after draw");

	// the input side only stalls because of a draw
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && operation == OP_DRAW))
		else $error("input stall without draw");

	// disabled pixels carry zero address and colour
	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> (pixel_address == '0) && (pixel_colour == '0))
		else $error("disabled pixel not zero");

endmodule

bind sprite_blitter_flip_palette spbf_checker u_spbf_checker (.*);

`default_nettype wire

@@ tb/spbf_pixel_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbf_pixel_checker
// watches the palette port and both channels of the sprite blitter, keeps a
// mirror of the sheet and palette, expands each draw into its 64 pixels and
// compares every pixel transaction in order
// ----------------------------------------------------------------------------
module spbf_pixel_checker #(
	parameter int SCREEN_SIZE   = 128,
	parameter int SHEET_SPRITES = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [spbf_pkg::PALETTE_W-1:0]      cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                operation,
	input  logic [spbf_pkg::SPRITE_W-1:0]       sprite_number,
	input  logic signed [8:0]                   screen_x,
	input  logic signed [8:0]                   screen_y,
	input  logic                                flip_horizontal,
	input  logic                                flip_vertical,
	input  logic [spbf_pkg::SHEET_AW-1:0]       load_address,
	input  logic [spbf_pkg::BYTE_W-1:0]         load_byte,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [spbf_pkg::PIX_AW-1:0]         pixel_address,
	input  logic [spbf_pkg::COLOUR_W-1:0]       pixel_colour,
	input  logic                                write_enable,
	input  logic                                last,
	output int                                  pixels_due,
	output int                                  pixels_seen,
	output int                                  mismatches
);

	typedef struct packed {
		logic [spbf_pkg::PIX_AW-1:0]   addr;
		logic [spbf_pkg::COLOUR_W-1:0] colour;
		logic                          wen;
		logic                          tail;
	} pixel_t;

	logic [spbf_pkg::BYTE_W-1:0]    sheet_mirror [0:spbf_pkg::SHEET_DEPTH-1];
	logic [spbf_pkg::PALETTE_W-1:0] palette_now;
	pixel_t                         pixels_owed [$];

	initial begin
		pixels_due  = 0;
		pixels_seen = 0;
		mismatches  = 0;
		palette_now = spbf_pkg::PALETTE_RESET;
	end

	task automatic complain(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at %0t, pixel %0d: %s got %0d expected %0d",
				$time, pixels_seen, what, got, want);
	endtask

	// row-major over the screen footprint, sheet position mirrored per flip
	task automatic expand_sprite(input logic [7:0] num, input logic signed [8:0] sx,
		input logic signed [8:0] sy, input logic fh, input logic fv);
		int base;
		int row;
		int col;
		int srow;
		int scol;
		int full;
		logic [7:0] b;
		logic on;
		pixel_t p;
		base = (int'(num) % SHEET_SPRITES) * 64;
		for (int dy = 0; dy < 8; dy++) begin
			row  = int'(sy) + dy;
			srow = fv ? 7 - dy : dy;
			for (int dx = 0; dx < 8; dx++) begin
				col  = int'(sx) + dx;
				scol = fh ? 7 - dx : dx;
				b    = sheet_mirror[(base + srow * 8 + scol) & (spbf_pkg::SHEET_DEPTH - 1)];
				on   = col >= 0 && col < SCREEN_SIZE && row >= 0 && row < SCREEN_SIZE;
				full = row * SCREEN_SIZE + col;
				p.wen    = on && b != 8'd0;
				p.addr   = p.wen ? full[spbf_pkg::PIX_AW-1:0] : '0;
				p.colour = p.wen ? palette_now[4 * b[3:0] +: 4] : 4'd0;
				p.tail   = dy == 7 && dx == 7;
				pixels_owed.push_back(p);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			palette_now = spbf_pkg::PALETTE_RESET;
			pixels_owed.delete();
		end else begin
			if (cfg_write)
				palette_now = cfg_data;
			if (in_valid && !in_stall) begin
				if (operation == spbf_pkg::OP_LOAD)
					sheet_mirror[load_address] = load_byte;
				else
					expand_sprite(sprite_number, screen_x, screen_y,
						flip_horizontal, flip_vertical);
			end
			if (out_valid && !out_stall) begin
				if (pixels_owed.size() == 0) begin
					complain("pixel with nothing owed, address", int'(pixel_address), 0);
				end else begin
					want = pixels_owed.pop_front();
					if (pixel_address !== want.addr)
						complain("pixel_address", int'(pixel_address), int'(want.addr));
					if (pixel_colour !== want.colour)
						complain("pixel_colour", int'(pixel_colour), int'(want.colour));
					if (write_enable !== want.wen)
						complain("write_enable", int'(write_enable), int'(want.wen));
					if (last !== want.tail)
						complain("last", int'(last), int'(want.tail));
				end
				pixels_seen++;
			end
		end
		pixels_due = pixels_owed.size();
	end

endmodule

@@ tb/tb_sprite_blitter_flip_palette.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sprite_blitter_flip_palette
// loads sprite sheet bytes and draws sprites at edge, clipped and random
// positions with all flip modes under several palettes, with random idling on
// both channels and one long output hold; a side checker predicts and checks
// ----------------------------------------------------------------------------
module tb_sprite_blitter_flip_palette;
	import spbf_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before giving up
	localparam int LONG_HOLD      = 400;   // one long output back-pressure stretch
	localparam int SETTLE_CYCLES  = 8;     // loads give no pixel, let them land
	localparam int ITEMS_PER_RUN  = 110;   // random transactions per idling mix

	// sheet fill patterns
	localparam int FILL_RAMP    = 0;
	localparam int FILL_DESCEND = 1;
	localparam int FILL_RANDOM  = 2;

	logic                   clk             = 1'b0;
	logic                   arst_n          = 1'b0;
	logic                   cfg_write       = 1'b0;
	logic [PALETTE_W-1:0]   cfg_data        = '0;
	logic                   in_valid        = 1'b0;
	logic                   in_stall;
	logic                   operation       = OP_LOAD;
	logic [SPRITE_W-1:0]    sprite_number   = '0;
	logic signed [8:0]      screen_x        = '0;
	logic signed [8:0]      screen_y        = '0;
	logic                   flip_horizontal = 1'b0;
	logic                   flip_vertical   = 1'b0;
	logic [SHEET_AW-1:0]    load_address    = '0;
	logic [BYTE_W-1:0]      load_byte       = '0;
	logic                   out_valid;
	logic                   out_stall       = 1'b0;
	logic [PIX_AW-1:0]      pixel_address;
	logic [COLOUR_W-1:0]    pixel_colour;
	logic                   write_enable;
	logic                   last;

	int pixels_due;
	int pixels_seen;
	int mismatches;

	// stimulus bookkeeping
	int   idle_pct  = 8;       // sender gap chance per transaction
	int   stall_pct = 83;      // receiver stall chance per cycle
	logic hold_go   = 1'b0;    // asks the receiver for its one long hold
	int   items_sent;
	int   loads_sent;
	int   draws_sent;
	int   palette_writes;
	logic [7:0] ready_sprites [$];  // sprites whose 64 bytes are all loaded
	bit         sprite_loaded [0:255];

	// receiver side state
	int   hold_left  = 0;
	logic hold_taken = 1'b0;

	// watchdog
	int quiet_cycles = 0;

	sprite_blitter_flip_palette u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.sprite_number   (sprite_number),
		.screen_x        (screen_x),
		.screen_y        (screen_y),
		.flip_horizontal (flip_horizontal),
		.flip_vertical   (flip_vertical),
		.load_address    (load_address),
		.load_byte       (load_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pixel_address   (pixel_address),
		.pixel_colour    (pixel_colour),
		.write_enable    (write_enable),
		.last            (last)
	);

	spbf_pixel_checker u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.sprite_number   (sprite_number),
		.screen_x        (screen_x),
		.screen_y        (screen_y),
		.flip_horizontal (flip_horizontal),
		.flip_vertical   (flip_vertical),
		.load_address    (load_address),
		.load_byte       (load_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pixel_address   (pixel_address),
		.pixel_colour    (pixel_colour),
		.write_enable    (write_enable),
		.last            (last),
		.pixels_due      (pixels_due),
		.pixels_seen     (pixels_seen),
		.mismatches      (mismatches)
	);

	always #5 clk = ~clk;

	// receiver: random stalls, except for one long hold counted here so the
	// blitter backs up and has to stall its own input
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_taken) begin
			out_stall  <= 1'b1;
			hold_left  <= LONG_HOLD - 1;
			hold_taken <= 1'b1;
		end else
			out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// watchdog: any accepted transaction on either channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d pixels still owed",
				quiet_cycles, pixels_due);
			$display("tb_sprite_blitter_flip_palette NOT OK");
			$finish;
		end
	end

	// one input transaction; called at a rising edge, returns at the edge
	// where it was taken with valid still high so back-to-back items flow
	task automatic put_item(input op_t op, input logic [7:0] num,
		input logic signed [8:0] sx, input logic signed [8:0] sy,
		input logic fh, input logic fv, input logic [13:0] addr, input logic [7:0] data);
		logic taken;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		operation       <= op;
		sprite_number   <= num;
		screen_x        <= sx;
		screen_y        <= sy;
		flip_horizontal <= fh;
		flip_vertical   <= fv;
		load_address    <= addr;
		load_byte       <= data;
		// stall is looked at mid-cycle, away from the edge
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		items_sent++;
	endtask

	// unused fields of a transaction carry random noise
	task automatic put_load(input logic [13:0] addr, input logic [7:0] data);
		put_item(OP_LOAD, 8'($urandom), 9'($urandom), 9'($urandom), 1'($urandom),
			1'($urandom), addr, data);
		loads_sent++;
	endtask

	task automatic put_draw(input logic [7:0] num, input logic signed [8:0] sx,
		input logic signed [8:0] sy, input logic fh, input logic fv);
		put_item(OP_DRAW, num, sx, sy, fh, fv, 14'($urandom), 8'($urandom));
		draws_sent++;
	endtask

	// all 64 bytes of one sprite, after which it may be drawn
	task automatic fill_sprite(input logic [7:0] num, input int style);
		logic [7:0] data;
		for (int k = 0; k < 64; k++) begin
			case (style)
				FILL_RAMP:    data = 8'(k);
				FILL_DESCEND: data = 8'(255 - k);
				default:      data = ($urandom_range(0, 3) == 0) ? 8'd0
					: 8'($urandom_range(1, 255));
			endcase
			put_load({num, 6'(k)}, data);
		end
		if (!sprite_loaded[num]) begin
			sprite_loaded[num] = 1'b1;
			ready_sprites.push_back(num);
		end
	endtask

	// sender pause: nothing offered until every owed pixel is back, then a
	// settling wait so trailing loads are written too
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pixels_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called after drain, so the blitter is idle
	task automatic set_palette(input logic [PALETTE_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		palette_writes++;
	endtask

	// mostly draws of loaded sprites, with sprite refills, stray sheet writes
	// and the odd pause; with_hold triggers the long output hold a third in
	task automatic random_run(input int n_items, input bit with_hold);
		int first;
		int pick;
		logic signed [8:0] sx;
		logic signed [8:0] sy;
		first = items_sent;
		while (items_sent - first < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				fill_sprite(8'($urandom_range(0, 255)), FILL_RANDOM);
			end else if (pick < 22) begin
				put_load(14'($urandom), ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom));
			end else if (pick < 24) begin
				drain();
			end else begin
				if ($urandom_range(0, 1)) begin
					// near or across the screen border
					sx = 9'($urandom_range(0, 140) - 10);
					sy = 9'($urandom_range(0, 140) - 10);
				end else begin
					sx = 9'($urandom);
					sy = 9'($urandom);
				end
				put_draw(ready_sprites[$urandom_range(0, ready_sprites.size() - 1)],
					sx, sy, 1'($urandom), 1'($urandom));
			end
			if (with_hold && !hold_go && items_sent - first >= n_items / 3)
				hold_go <= 1'b1;
		end
	endtask

	initial begin
		items_sent     = 0;
		loads_sent     = 0;
		draws_sent     = 0;
		palette_writes = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// first mix: sender rarely idles, receiver mostly stalls
		// sprite 0 is a ramp (transparent top-left byte, zero low nibbles
		// further on), sprite 255 covers the top of the sheet and high bits
		fill_sprite(8'd0, FILL_RAMP);
		fill_sprite(8'd255, FILL_DESCEND);

		// reset palette: every flip mode, clipping on each border, fully off
		// screen at both extremes of the position range, single pixel corner
		put_draw(8'd0, 0, 0, 1'b0, 1'b0);
		put_draw(8'd0, 20, 30, 1'b1, 1'b0);
		put_draw(8'd0, 20, 30, 1'b0, 1'b1);
		put_draw(8'd0, 20, 30, 1'b1, 1'b1);
		put_draw(8'd255, 121, 123, 1'b0, 1'b0);
		put_draw(8'd255, -3, -5, 1'b1, 1'b0);
		put_draw(8'd0, -256, -256, 1'b0, 1'b0);
		put_draw(8'd255, 255, 255, 1'b1, 1'b1);
		put_draw(8'd0, 127, 0, 1'b0, 1'b1);
		put_draw(8'd0, 0, 127, 1'b1, 1'b0);
		put_draw(8'd255, -7, -7, 1'b0, 1'b0);
		put_draw(8'd0, 120, 120, 1'b0, 1'b0);
		put_draw(8'd0, 124, -4, 1'b1, 1'b1);
		put_draw(8'd0, -8, 60, 1'b0, 1'b0);

		// all-zero palette, then a reversed one
		drain();
		set_palette('0);
		put_draw(8'd255, 50, 50, 1'b0, 1'b0);
		put_draw(8'd0, 8, 8, 1'b0, 1'b0);
		drain();
		set_palette(64'h0123_4567_89AB_CDEF);
		put_draw(8'd0, 64, 64, 1'b1, 1'b1);
		put_draw(8'd255, 100, 2, 1'b0, 1'b1);

		// random part, all-ones palette
		drain();
		set_palette('1);
		random_run(ITEMS_PER_RUN, 1'b0);

		// second mix: sender mostly idle, receiver rarely stalls
		drain();
		idle_pct  = 83;
		stall_pct <= 8;
		set_palette({$urandom, $urandom});
		random_run(ITEMS_PER_RUN, 1'b0);

		// third mix: no idling at all, plus the long output hold
		drain();
		idle_pct  = 0;
		stall_pct <= 0;
		set_palette({$urandom, $urandom});
		random_run(ITEMS_PER_RUN, 1'b1);

		// everything owed back, then a settling wait for strays
		drain();
		$display("covered %0d sheet loads and %0d sprite draws, %0d pixel transactions,",
			loads_sent, draws_sent, pixels_seen);
		$display("%0d palette writes, three idling mixes and a %0d-cycle output hold",
			palette_writes, LONG_HOLD);
		if (mismatches == 0)
			$display("tb_sprite_blitter_flip_palette OK");
		else
			$display("tb_sprite_blitter_flip_palette NOT OK");
		$finish;
	end

endmodule
